// File: rtl/dlfd_pkg.sv
// ----------------------------------------------------------------------------
// dlfd_pkg
// Shared types and constants for the delimited length frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dlfd_pkg;

  // Header layout: start byte, 2-byte type, 8-byte sender id, 4-byte length
  localparam int unsigned HEADER_BYTES = 15;
  localparam logic [3:0]  HDR_START_POS = 4'd0;
  localparam logic [3:0]  HDR_TYPE_END  = 4'd2;
  localparam logic [3:0]  HDR_LEN_POS   = 4'd11;
  localparam logic [3:0]  HDR_LAST_POS  = 4'(HEADER_BYTES - 1);

  // Delimiters
  localparam logic [7:0] START_MARK = 8'h24;
  localparam logic [7:0] END_MARK   = 8'h23;

  // Register reset value
  localparam logic [20:0] MAX_BODY_LEN_RST = 21'd65536;

  // Largest value of the 21-bit length field
  localparam logic [31:0] LEN21_MAX = 32'h001F_FFFF;

  // Result kind codes
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DELIM = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [15:0] frame_type;
    logic [63:0] sender_id;
    logic [20:0] body_length;
    logic [19:0] body_offset;
    logic [7:0]  body_byte;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // Saturate a 32-bit declared length to the 21-bit field
  function automatic logic [20:0] sat_len21(input logic [31:0] len);
    logic [20:0] r;
    if (len > LEN21_MAX) begin
      r = '1;
    end else begin
      r = len[20:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dlfd_parse.sv
// ----------------------------------------------------------------------------
// dlfd_parse
// Frame parser: header collection, body counting and trailer check, one byte
// per cycle while in_accept is high. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfd_parse #(
  parameter int unsigned BODY_COUNT_BITS = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_accept,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic [20:0]      max_body_len,
  output dlfd_pkg::res_t        res,
  output logic                  res_valid
);

  localparam int unsigned CntW = BODY_COUNT_BITS;
  // Largest count the body counter holds
  localparam logic [32:0] CountMax = (33'd1 << CntW) - 33'd1;

  dlfd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       header_count_r, header_count_nxt;
  logic [7:0]       start_byte_r, start_byte_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [63:0]      sender_r, sender_nxt;
  logic [31:0]      length_r, length_nxt;
  logic [CntW-1:0]  body_count_r, body_count_nxt;
  logic [31:0]      count32;
  logic             too_long;
  logic             res_hit;
  logic             kind;
  logic [19:0]      offset;
  logic [7:0]       obyte;
  logic [1:0]       status;

  assign count32 = 32'(body_count_r);

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    start_byte_nxt   = start_byte_r;
    type_nxt         = type_r;
    sender_nxt       = sender_r;
    length_nxt       = length_r;
    body_count_nxt   = body_count_r;
    res_hit          = 1'b0;
    kind             = dlfd_pkg::KIND_BODY;
    offset           = count32[19:0];
    obyte            = 8'd0;
    status           = dlfd_pkg::ST_OK;
    too_long         = 1'b0;

    case (phase_r)
      dlfd_pkg::PH_BODY: begin
        res_hit        = 1'b1;
        obyte          = in_rx_byte;
        body_count_nxt = body_count_r + {{(CntW-1){1'b0}}, 1'b1};
        if (32'(body_count_nxt) >= length_r) begin
          phase_nxt = dlfd_pkg::PH_TRAILER;
        end
      end
      dlfd_pkg::PH_TRAILER: begin
        res_hit = 1'b1;
        kind    = dlfd_pkg::KIND_END;
        if (start_byte_r != dlfd_pkg::START_MARK || in_rx_byte != dlfd_pkg::END_MARK) begin
          status = dlfd_pkg::ST_BAD_DELIM;
        end
        phase_nxt        = dlfd_pkg::PH_HEADER;
        header_count_nxt = 4'd0;
        body_count_nxt   = '0;
      end
      dlfd_pkg::PH_HEADER: begin
        // Shift the byte into its header field
        if (header_count_r == dlfd_pkg::HDR_START_POS) begin
          start_byte_nxt = in_rx_byte;
          type_nxt       = 16'd0;
          sender_nxt     = 64'd0;
          length_nxt     = 32'd0;
        end else if (header_count_r <= dlfd_pkg::HDR_TYPE_END) begin
          type_nxt = {type_r[7:0], in_rx_byte};
        end else if (header_count_r < dlfd_pkg::HDR_LEN_POS) begin
          sender_nxt = {sender_r[55:0], in_rx_byte};
        end else begin
          length_nxt = {length_r[23:0], in_rx_byte};
        end
        header_count_nxt = header_count_r + 4'd1;
        // Close the header on its last byte
        if (header_count_r == dlfd_pkg::HDR_LAST_POS) begin
          header_count_nxt = 4'd0;
          body_count_nxt   = '0;
          too_long = (length_nxt > 32'(max_body_len)) || ({1'b0, length_nxt} > CountMax);
          if (too_long) begin
            res_hit   = 1'b1;
            kind      = dlfd_pkg::KIND_END;
            offset    = 20'd0;
            status    = dlfd_pkg::ST_TOO_LONG;
            phase_nxt = dlfd_pkg::PH_HEADER;
          end else if (length_nxt == 32'd0) begin
            phase_nxt = dlfd_pkg::PH_TRAILER;
          end else begin
            phase_nxt = dlfd_pkg::PH_BODY;
          end
        end
      end
      default: begin
        phase_nxt = dlfd_pkg::PH_HEADER;
      end
    endcase
  end

  // Assemble the result beat
  always_comb begin
    res.kind        = kind;
    res.frame_type  = type_nxt;
    res.sender_id   = sender_nxt;
    res.body_length = dlfd_pkg::sat_len21(length_nxt);
    res.body_offset = offset;
    res.body_byte   = obyte;
    res.status      = status;
    res.last        = kind;
    res_valid       = in_accept & res_hit;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= dlfd_pkg::PH_HEADER;
      header_count_r <= 4'd0;
      start_byte_r   <= 8'd0;
      type_r         <= 16'd0;
      sender_r       <= 64'd0;
      length_r       <= 32'd0;
      body_count_r   <= '0;
    end else if (in_accept) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      start_byte_r   <= start_byte_nxt;
      type_r         <= type_nxt;
      sender_r       <= sender_nxt;
      length_r       <= length_nxt;
      body_count_r   <= body_count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dlfd_skid.sv
// ----------------------------------------------------------------------------
// dlfd_skid
// Two-entry output buffer: a main result register plus a skid register, so
// the input stall is a registered signal.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfd_skid (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dlfd_pkg::res_t res,
  input  wire logic           res_valid,
  output logic                full,
  output dlfd_pkg::res_t      out_res,
  output logic                out_valid,
  input  wire logic           out_stall
);

  dlfd_pkg::res_t main_r, skid_r;
  logic           main_valid_r, skid_valid_r;

  assign full      = skid_valid_r;
  assign out_res   = main_r;
  assign out_valid = main_valid_r;

  // Control: load main when free, park in skid when main is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!main_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (res_valid) begin
        main_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/delimited_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// delimited_length_frame_deframer
// Recovers start/type/sender/length/body/trailer frames from a byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, in_rx_byte) carries one stream byte per
// beat. Output channel (out_valid, out_stall, out_*) carries one result per
// beat: a body byte tagged with the frame header, or a frame-end beat with
// status and last set. Header bytes produce no beat, but for the too-long case below.
// cfg_valid/cfg_ready write max_body_len; cfg_ready is always high. Write it
// only while no frame is in flight.
// Throughput: one byte per cycle while in_stall is low. A result is registered
// in the output register (or the skid register while the output stalls); all
// parsing happens in a single pass between parser and output registers.
// The output has two result registers; in_stall rises only when both hold
// results, so header bytes keep flowing while one result waits.
// Reset (rst_n low, synchronous) returns the parser to header hunting,
// empties the output and sets max_body_len to 65536.
// A declared length above max_body_len (or beyond the body counter) yields a
// frame-end beat with status too-long right after the header; the next byte
// starts a new header.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_length_frame_deframer #(
  parameter int unsigned BODY_COUNT_BITS = 21
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [15:0]      out_frame_type,
  output logic [63:0]      out_sender_id,
  output logic [20:0]      out_body_length,
  output logic [19:0]      out_body_offset,
  output logic [7:0]       out_body_byte,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [20:0] cfg_max_body_len
);

  logic [20:0]    max_len_r;
  logic           in_accept;
  logic           full;
  dlfd_pkg::res_t res, out_res;
  logic           res_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid & ~full;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= dlfd_pkg::MAX_BODY_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_body_len;
    end
  end

  dlfd_parse #(
    .BODY_COUNT_BITS(BODY_COUNT_BITS)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_rx_byte   (in_rx_byte),
    .max_body_len (max_len_r),
    .res          (res),
    .res_valid    (res_valid)
  );

  dlfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_valid (res_valid),
    .full      (full),
    .out_res   (out_res),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  assign out_kind        = out_res.kind;
  assign out_frame_type  = out_res.frame_type;
  assign out_sender_id   = out_res.sender_id;
  assign out_body_length = out_res.body_length;
  assign out_body_offset = out_res.body_offset;
  assign out_body_byte   = out_res.body_byte;
  assign out_status      = out_res.status;
  assign out_last        = out_res.last;

endmodule

`default_nettype wire

// File: rtl/dlfd_checker.sv
// ----------------------------------------------------------------------------
// dlfd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [19:0] out_body_offset,
  input wire logic [7:0]  out_body_byte,
  input wire logic [1:0]  out_status,
  input wire logic        out_last
);

  // Hold a stalled result beat
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_body_byte)
      && $stable(out_body_offset) && $stable(out_status))
    else $error("stalled result payload changed");

  // Last marks exactly the frame-end beats
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == out_kind)
    else $error("last flag disagrees with result kind");

  // Body beats always report ok; no beat uses the spare status code
  a_body_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != dlfd_pkg::ST_UNUSED)
      && (out_kind == dlfd_pkg::KIND_END || out_status == dlfd_pkg::ST_OK))
    else $error("bad status on result beat");

  // Frame-end beats carry no body byte
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == dlfd_pkg::KIND_END |-> out_body_byte == 8'd0)
    else $error("frame-end beat carries a body byte");

endmodule

bind delimited_length_frame_deframer dlfd_checker u_dlfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_body_offset (out_body_offset),
  .out_body_byte   (out_body_byte),
  .out_status      (out_status),
  .out_last        (out_last)
);

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delimited_length_frame_deframer.
// A queue of stream bytes feeds a clocked driver; a clocked monitor runs a
// frame parser model on every accepted byte and compares each result beat,
// field by field, with the oldest predicted beat. Phases change the
// max_body_len setting and the idle/stall pattern of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 50;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [15:0] out_frame_type;
  logic [63:0] out_sender_id;
  logic [20:0] out_body_length;
  logic [19:0] out_body_offset;
  logic [7:0]  out_body_byte;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [20:0] cfg_max_body_len = 21'd0;

  // Stimulus and expectation stores
  logic [7:0]     pending_bytes[$];
  dlfd_pkg::res_t expected_beats[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int queued_bytes = 0;
  int taken_bytes = 0;
  int body_beats = 0;
  int ends_ok = 0;
  int ends_bad = 0;
  int ends_long = 0;

  // Parser model state
  dlfd_pkg::phase_t pm_phase = dlfd_pkg::PH_HEADER;
  logic [3:0]  pm_hdr_cnt = '0;
  logic [7:0]  pm_start = '0;
  logic [15:0] pm_type = '0;
  logic [63:0] pm_sender = '0;
  logic [31:0] pm_len = '0;
  logic [20:0] pm_body_cnt = '0;
  logic [20:0] pm_max_len = dlfd_pkg::MAX_BODY_LEN_RST;

  delimited_length_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_frame_type   (out_frame_type),
    .out_sender_id    (out_sender_id),
    .out_body_length  (out_body_length),
    .out_body_offset  (out_body_offset),
    .out_body_byte    (out_body_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_body_len (cfg_max_body_len)
  );

  always #2 clk = ~clk;

  // Build one result beat from the current header fields
  function automatic dlfd_pkg::res_t frame_beat(logic kind, logic [20:0] offset,
                                                logic [7:0] data, logic [1:0] status);
    dlfd_pkg::res_t r;
    r.kind        = kind;
    r.frame_type  = pm_type;
    r.sender_id   = pm_sender;
    r.body_length = (pm_len > dlfd_pkg::LEN21_MAX) ? '1 : pm_len[20:0];
    r.body_offset = offset[19:0];
    r.body_byte   = data;
    r.status      = status;
    r.last        = (kind == dlfd_pkg::KIND_END);
    return r;
  endfunction

  // Append one predicted beat
  task automatic expect_beat(input dlfd_pkg::res_t r);
    expected_beats.insert(expected_beats.size(), r);
  endtask

  // Append one stream byte
  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  // Advance the parser model by one stream byte, queue any beat it yields
  task automatic deframe_byte(input logic [7:0] b);
    logic [1:0] st;
    case (pm_phase)
      dlfd_pkg::PH_BODY: begin
        expect_beat(frame_beat(dlfd_pkg::KIND_BODY, pm_body_cnt, b, dlfd_pkg::ST_OK));
        pm_body_cnt = pm_body_cnt + 21'd1;
        if ({11'd0, pm_body_cnt} >= pm_len) begin
          pm_phase = dlfd_pkg::PH_TRAILER;
        end
      end
      dlfd_pkg::PH_TRAILER: begin
        st = (pm_start == dlfd_pkg::START_MARK && b == dlfd_pkg::END_MARK) ?
             dlfd_pkg::ST_OK : dlfd_pkg::ST_BAD_DELIM;
        expect_beat(frame_beat(dlfd_pkg::KIND_END, pm_body_cnt, 8'd0, st));
        pm_phase    = dlfd_pkg::PH_HEADER;
        pm_hdr_cnt  = '0;
        pm_body_cnt = '0;
      end
      default: begin
        if (pm_hdr_cnt == dlfd_pkg::HDR_START_POS) begin
          pm_start  = b;
          pm_type   = '0;
          pm_sender = '0;
          pm_len    = '0;
        end else if (pm_hdr_cnt <= dlfd_pkg::HDR_TYPE_END) begin
          pm_type = {pm_type[7:0], b};
        end else if (pm_hdr_cnt < dlfd_pkg::HDR_LEN_POS) begin
          pm_sender = {pm_sender[55:0], b};
        end else begin
          pm_len = {pm_len[23:0], b};
        end
        if (pm_hdr_cnt == dlfd_pkg::HDR_LAST_POS) begin
          pm_hdr_cnt  = '0;
          pm_body_cnt = '0;
          if (pm_len > {11'd0, pm_max_len} || pm_len > dlfd_pkg::LEN21_MAX) begin
            expect_beat(frame_beat(dlfd_pkg::KIND_END, 21'd0, 8'd0, dlfd_pkg::ST_TOO_LONG));
            pm_phase = dlfd_pkg::PH_HEADER;
          end else begin
            pm_phase = (pm_len == 32'd0) ? dlfd_pkg::PH_TRAILER : dlfd_pkg::PH_BODY;
          end
        end else begin
          pm_hdr_cnt = pm_hdr_cnt + 4'd1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Drive stream beats; hold a stalled beat unchanged
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on accepted bytes, check accepted result beats, drive stall
  always @(posedge clk) begin
    dlfd_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        taken_bytes++;
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expectation pending: kind %0b status %0d",
                 out_kind, out_status);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_kind));
          check_field("frame_type", 64'(want.frame_type), 64'(out_frame_type));
          check_field("sender_id", want.sender_id, out_sender_id);
          check_field("body_length", 64'(want.body_length), 64'(out_body_length));
          check_field("body_offset", 64'(want.body_offset), 64'(out_body_offset));
          check_field("body_byte", 64'(want.body_byte), 64'(out_body_byte));
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("last", 64'(want.last), 64'(out_last));
          if (want.kind == dlfd_pkg::KIND_BODY) begin
            body_beats++;
          end else if (want.status == dlfd_pkg::ST_OK) begin
            ends_ok++;
          end else if (want.status == dlfd_pkg::ST_BAD_DELIM) begin
            ends_bad++;
          end else begin
            ends_long++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Queue one frame; too-long headers carry no body or trailer
  task automatic add_frame(input logic [7:0] sb, input logic [15:0] ftype,
                           input logic [63:0] sid, input logic [31:0] len,
                           input logic [7:0] tb, input bit with_tail);
    queue_byte(sb);
    queue_byte(ftype[15:8]);
    queue_byte(ftype[7:0]);
    for (int i = 7; i >= 0; i--) queue_byte(sid[8*i +: 8]);
    for (int i = 3; i >= 0; i--) queue_byte(len[8*i +: 8]);
    queued_bytes += dlfd_pkg::HEADER_BYTES;
    if (with_tail) begin
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
      queue_byte(tb);
      queued_bytes += len + 1;
    end
  endtask

  // Mostly short bodies, now and then a longer one
  function automatic int pick_len(input int max_len);
    int lim;
    lim = (max_len < 16) ? max_len : 16;
    if ($urandom_range(0, 19) == 0) lim = (max_len < 300) ? max_len : 300;
    return $urandom_range(0, lim);
  endfunction

  task automatic add_random_frame(input int max_len);
    int          pick;
    logic [7:0]  sb;
    logic [7:0]  tb;
    logic [15:0] ftype;
    logic [63:0] sid;
    logic [31:0] len;
    pick  = $urandom_range(0, 99);
    sb    = dlfd_pkg::START_MARK;
    tb    = dlfd_pkg::END_MARK;
    ftype = 16'($urandom);
    sid   = {$urandom, $urandom};
    len   = pick_len(max_len);
    if (pick < 60) begin
      add_frame(sb, ftype, sid, len, tb, 1'b1);
    end else if (pick < 70) begin
      // bad start byte
      do sb = 8'($urandom); while (sb == dlfd_pkg::START_MARK);
      add_frame(sb, ftype, sid, len, tb, 1'b1);
    end else if (pick < 78) begin
      // bad trailer byte
      do tb = 8'($urandom); while (tb == dlfd_pkg::END_MARK);
      add_frame(sb, ftype, sid, len, tb, 1'b1);
    end else if (pick < 88) begin
      // declared length just over the limit
      add_frame(sb, ftype, sid, max_len + 1 + $urandom_range(0, 1000), tb, 1'b0);
    end else begin
      // garbage header whose length is far beyond any limit
      sb  = 8'($urandom);
      len = {8'($urandom_range(1, 255)), 24'($urandom)};
      add_frame(sb, ftype, sid, len, tb, 1'b0);
    end
  endtask

  // Hold until every byte is taken and every predicted beat has arrived
  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [20:0] value);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_max_body_len <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pm_max_len = value;
    @(negedge clk);
  endtask

  // Stimulus: per phase set the limit, the idle and stall pattern, then queue frames
  initial begin
    int settings[PHASES];
    int start_count;
    settings = '{65536, 0, 3, 1048576, 1048575, 1, 255, 65536};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_max_len(21'(settings[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (p == 0) begin
        add_frame(dlfd_pkg::START_MARK, 16'hFFFF, '1, 32'd2, dlfd_pkg::END_MARK, 1'b1);
        add_frame(dlfd_pkg::START_MARK, 16'h0000, '0, 32'd0, dlfd_pkg::END_MARK, 1'b1);
        add_frame(8'h00, 16'h1234, 64'h0123_4567_89AB_CDEF, 32'd1, dlfd_pkg::END_MARK,
                  1'b1);
        add_frame(dlfd_pkg::START_MARK, 16'h00FF, 64'hFEDC_BA98_7654_3210, 32'd3, 8'hFF,
                  1'b1);
        add_frame(8'hFF, 16'hFF00, 64'h5555_AAAA_5555_AAAA, 32'd0, 8'h00, 1'b1);
        add_frame(dlfd_pkg::START_MARK, 16'hA5A5, 64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFFF,
                  dlfd_pkg::END_MARK, 1'b0);
      end
      // Limit edges: exactly at the limit where cheap, one past it always
      if (settings[p] <= 300) begin
        add_frame(dlfd_pkg::START_MARK, 16'($urandom), {$urandom, $urandom}, settings[p],
                  dlfd_pkg::END_MARK, 1'b1);
      end
      add_frame(dlfd_pkg::START_MARK, 16'($urandom), {$urandom, $urandom}, settings[p] + 1,
                dlfd_pkg::END_MARK, 1'b0);
      if (settings[p] >= 1048575) begin
        add_frame(dlfd_pkg::START_MARK, 16'($urandom), {$urandom, $urandom}, 32'h001F_FFFF,
                  dlfd_pkg::END_MARK, 1'b0);
        add_frame(dlfd_pkg::START_MARK, 16'($urandom), {$urandom, $urandom}, 32'h0020_0000,
                  dlfd_pkg::END_MARK, 1'b0);
      end
      start_count = queued_bytes;
      while (queued_bytes - start_count < PHASE_BYTES) add_random_frame(settings[p]);
    end
    settle();
    $display("Streamed %0d bytes over %0d limit settings and four idle patterns;",
             taken_bytes, PHASES);
    $display("checked %0d body beats and %0d/%0d/%0d ok/bad-delimiter/too-long frame ends.",
             body_beats, ends_ok, ends_bad, ends_long);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1600000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dlfd_pkg.sv
rtl/dlfd_parse.sv
rtl/dlfd_skid.sv
rtl/delimited_length_frame_deframer.sv
rtl/dlfd_checker.sv
sim/testbench.sv
